@@ design/sbd_pkg.sv @@
// sbd_pkg: shared constants, types, reciprocal tables and clamp helpers
// for the supersample box downsampler. No dependencies.
package sbd_pkg;

  // limits of the mask geometry
  localparam int MAX_HI_WIDTH = 4096;
  localparam int MAX_SS       = 8;
  localparam int HEIGHT_LIMIT = 4096;

  // field and state widths
  localparam int SS_W    = 4;
  localparam int IDX_W   = $clog2(MAX_SS);
  localparam int DIM_W   = 13;
  localparam int POS_W   = $clog2(MAX_HI_WIDTH);
  localparam int SUB_W   = 3;
  localparam int SUM_W   = 14;
  localparam int COV_W   = 8;
  localparam int COLOR_W = 8;
  localparam int ALPHA_W = 8;

  // configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // cycles the derived block limits need after a register write
  localparam logic [1:0] CFG_SETTLE = 2'd2;

  // output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = FIFO_AW + 1;
  localparam int OCC_W      = CNT_W + 1;

  // register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_SS     = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_RED    = 3'd3,
    REG_GREEN  = 3'd4,
    REG_BLUE   = 3'd5
  } reg_idx_t;

  // floor(n / ss) = (n * DIM_RECIP[ss-1]) >> DIM_K, exact for n < 2^13
  localparam int DIM_K  = 16;
  localparam int DIM_MW = 17;
  localparam logic [DIM_MW-1:0] DIM_RECIP [MAX_SS] = '{
    17'd65536, 17'd32768, 17'd21846, 17'd16384,
    17'd13108, 17'd10923, 17'd9363,  17'd8192
  };

  // floor(s / (ss*ss)) = (s * SQ_RECIP[ss-1]) >> SQ_K, exact for s < 2^14
  localparam int SQ_K  = 20;
  localparam int SQ_MW = 21;
  localparam logic [SQ_MW-1:0] SQ_RECIP [MAX_SS] = '{
    21'd1048576, 21'd262144, 21'd116509, 21'd65536,
    21'd41944,   21'd29128,  21'd21400,  21'd16384
  };

  // live configuration handed to the datapath
  typedef struct packed {
    logic [SS_W-1:0]    ss;
    logic [IDX_W-1:0]   ss_idx;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DIM_W-1:0]   col_limit;
    logic [DIM_W-1:0]   row_limit;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } cfg_t;

  // finished block sum leaving the accumulator
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic             frame_end;
  } sum_t;

  // block side forced into 1..MAX_SS
  function automatic logic [SS_W-1:0] clamp_ss(input logic [SS_W-1:0] v);
    logic [SS_W-1:0] r;
    r = v;
    if (v == '0) r = SS_W'(1);
    else if (v > SS_W'(MAX_SS)) r = SS_W'(MAX_SS);
    return r;
  endfunction

  // mask dimension forced into 1..lim
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

endpackage

@@ design/sbd_ram.sv @@
// sbd_ram: generic single-write, single-read synchronous RAM.
// Read data is registered and returns the old contents on a same-address write.
module sbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ design/sbd_cfg.sv @@
// sbd_cfg: APB register file, clamped settings and the block-aligned
// column and row limits. Depends on sbd_pkg.
module sbd_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbd_pkg::APB_AW-1:0] paddr,
  input  logic [sbd_pkg::APB_DW-1:0] pwdata,
  output logic [sbd_pkg::APB_DW-1:0] prdata,
  output sbd_pkg::cfg_t              cfg,
  output logic                       busy
);

  localparam logic [1:0] CFG_SETTLE_V = sbd_pkg::CFG_SETTLE;

  logic [sbd_pkg::SS_W-1:0]    ss_raw;
  logic [sbd_pkg::DIM_W-1:0]   width_raw;
  logic [sbd_pkg::DIM_W-1:0]   height_raw;
  logic [sbd_pkg::COLOR_W-1:0] red;
  logic [sbd_pkg::COLOR_W-1:0] green;
  logic [sbd_pkg::COLOR_W-1:0] blue;
  logic [1:0]                  settle;
  logic                        wr;
  sbd_pkg::reg_idx_t           idx;

  logic [sbd_pkg::SS_W-1:0]  ss;
  logic [sbd_pkg::IDX_W-1:0] ss_idx;
  logic [sbd_pkg::DIM_W-1:0] width;
  logic [sbd_pkg::DIM_W-1:0] height;
  logic [sbd_pkg::DIM_W+sbd_pkg::DIM_MW-1:0] col_prod;
  logic [sbd_pkg::DIM_W+sbd_pkg::DIM_MW-1:0] row_prod;
  logic [sbd_pkg::DIM_W-1:0] blocks_x;
  logic [sbd_pkg::DIM_W-1:0] blocks_y;
  logic [sbd_pkg::DIM_W+sbd_pkg::SS_W-1:0] col_lim_prod;
  logic [sbd_pkg::DIM_W+sbd_pkg::SS_W-1:0] row_lim_prod;
  logic [sbd_pkg::DIM_W-1:0] col_limit;
  logic [sbd_pkg::DIM_W-1:0] row_limit;

  assign wr  = psel && penable && pwrite;
  assign idx = sbd_pkg::reg_idx_t'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ss_raw     <= sbd_pkg::SS_W'(1);
      width_raw  <= sbd_pkg::DIM_W'(256);
      height_raw <= sbd_pkg::DIM_W'(256);
      red        <= '0;
      green      <= '0;
      blue       <= '0;
    end else if (wr) begin
      unique case (idx)
        sbd_pkg::REG_SS:     ss_raw     <= pwdata[sbd_pkg::SS_W-1:0];
        sbd_pkg::REG_WIDTH:  width_raw  <= pwdata[sbd_pkg::DIM_W-1:0];
        sbd_pkg::REG_HEIGHT: height_raw <= pwdata[sbd_pkg::DIM_W-1:0];
        sbd_pkg::REG_RED:    red        <= pwdata[sbd_pkg::COLOR_W-1:0];
        sbd_pkg::REG_GREEN:  green      <= pwdata[sbd_pkg::COLOR_W-1:0];
        sbd_pkg::REG_BLUE:   blue       <= pwdata[sbd_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      sbd_pkg::REG_SS:     prdata = sbd_pkg::APB_DW'(ss_raw);
      sbd_pkg::REG_WIDTH:  prdata = sbd_pkg::APB_DW'(width_raw);
      sbd_pkg::REG_HEIGHT: prdata = sbd_pkg::APB_DW'(height_raw);
      sbd_pkg::REG_RED:    prdata = sbd_pkg::APB_DW'(red);
      sbd_pkg::REG_GREEN:  prdata = sbd_pkg::APB_DW'(green);
      sbd_pkg::REG_BLUE:   prdata = sbd_pkg::APB_DW'(blue);
      default:             prdata = '0;
    endcase
  end

  // clamped settings
  assign ss     = sbd_pkg::clamp_ss(ss_raw);
  assign ss_idx = sbd_pkg::IDX_W'(ss - sbd_pkg::SS_W'(1));
  assign width  = sbd_pkg::clamp_dim(width_raw, sbd_pkg::DIM_W'(sbd_pkg::MAX_HI_WIDTH));
  assign height = sbd_pkg::clamp_dim(height_raw, sbd_pkg::DIM_W'(sbd_pkg::HEIGHT_LIMIT));

  // whole blocks per row and per column, by reciprocal multiply
  assign col_prod = {{sbd_pkg::DIM_MW{1'b0}}, width} *
                    {{sbd_pkg::DIM_W{1'b0}}, sbd_pkg::DIM_RECIP[ss_idx]};
  assign row_prod = {{sbd_pkg::DIM_MW{1'b0}}, height} *
                    {{sbd_pkg::DIM_W{1'b0}}, sbd_pkg::DIM_RECIP[ss_idx]};

  always_ff @(posedge clk) begin
    blocks_x <= col_prod[sbd_pkg::DIM_K +: sbd_pkg::DIM_W];
    blocks_y <= row_prod[sbd_pkg::DIM_K +: sbd_pkg::DIM_W];
  end

  // samples covered by whole blocks
  assign col_lim_prod = {{sbd_pkg::SS_W{1'b0}}, blocks_x} *
                        {{sbd_pkg::DIM_W{1'b0}}, ss};
  assign row_lim_prod = {{sbd_pkg::SS_W{1'b0}}, blocks_y} *
                        {{sbd_pkg::DIM_W{1'b0}}, ss};

  always_ff @(posedge clk) begin
    col_limit <= col_lim_prod[sbd_pkg::DIM_W-1:0];
    row_limit <= row_lim_prod[sbd_pkg::DIM_W-1:0];
  end

  // hold off the stream until the limits follow a write
  always_ff @(posedge clk) begin
    if (rst || wr) settle <= CFG_SETTLE_V;
    else if (settle != 2'd0) settle <= settle - 2'd1;
  end

  assign busy = (settle != 2'd0);

  always_comb begin
    cfg.ss        = ss;
    cfg.ss_idx    = ss_idx;
    cfg.width     = width;
    cfg.height    = height;
    cfg.col_limit = col_limit;
    cfg.row_limit = row_limit;
    cfg.red       = red;
    cfg.green     = green;
    cfg.blue      = blue;
  end

endmodule

@@ design/sbd_accum.sv @@
// sbd_accum: raster position counters and the per-block-column sum RAM with
// read-modify-write and write-to-read forwarding. Depends on sbd_pkg, sbd_ram.
module sbd_accum (
  input  logic                      clk,
  input  logic                      rst,
  input  sbd_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic [sbd_pkg::COV_W-1:0] coverage,
  output sbd_pkg::sum_t             acc
);

  // raster position
  logic [sbd_pkg::POS_W-1:0] sample_col, sample_col_next;
  logic [sbd_pkg::POS_W-1:0] sample_row, sample_row_next;
  logic [sbd_pkg::SUB_W-1:0] sub_col, sub_col_next;
  logic [sbd_pkg::SUB_W-1:0] sub_row, sub_row_next;
  logic [sbd_pkg::POS_W-1:0] block_col, block_col_next;

  logic [sbd_pkg::DIM_W-1:0] col_inc;
  logic [sbd_pkg::DIM_W-1:0] row_inc;
  logic                      in_block;
  logic                      first;
  logic                      last_blk;
  logic                      fend;

  // read-modify-write stage
  logic                      v1;
  logic                      emit1;
  logic                      first1;
  logic                      fend1;
  logic [sbd_pkg::COV_W-1:0] cov1;
  logic [sbd_pkg::POS_W-1:0] addr1;
  logic [sbd_pkg::SUM_W-1:0] rdata;
  logic [sbd_pkg::SUM_W-1:0] base;
  logic [sbd_pkg::SUM_W-1:0] sum;

  // last write, for a read that raced it
  logic                      fwd_v;
  logic [sbd_pkg::POS_W-1:0] fwd_addr;
  logic [sbd_pkg::SUM_W-1:0] fwd_sum;
  logic                      fwd_hit;

  // position tests
  always_comb begin
    col_inc  = {1'b0, sample_col} + sbd_pkg::DIM_W'(1);
    row_inc  = {1'b0, sample_row} + sbd_pkg::DIM_W'(1);
    in_block = ({1'b0, sample_col} < cfg.col_limit) && ({1'b0, sample_row} < cfg.row_limit);
    first    = (sub_col == '0) && (sub_row == '0);
    last_blk = (({1'b0, sub_col} + sbd_pkg::SS_W'(1)) >= cfg.ss) &&
               (({1'b0, sub_row} + sbd_pkg::SS_W'(1)) >= cfg.ss);
    fend     = (col_inc >= cfg.col_limit) && (row_inc >= cfg.row_limit);
  end

  // raster advance
  always_comb begin
    sample_col_next = sample_col;
    sample_row_next = sample_row;
    sub_col_next    = sub_col;
    sub_row_next    = sub_row;
    block_col_next  = block_col;
    if (in_valid) begin
      if (col_inc >= cfg.width) begin
        sample_col_next = '0;
        sub_col_next    = '0;
        block_col_next  = '0;
        if (row_inc >= cfg.height) begin
          sample_row_next = '0;
          sub_row_next    = '0;
        end else begin
          sample_row_next = row_inc[sbd_pkg::POS_W-1:0];
          if (({1'b0, sub_row} + sbd_pkg::SS_W'(1)) >= cfg.ss) sub_row_next = '0;
          else sub_row_next = sub_row + sbd_pkg::SUB_W'(1);
        end
      end else begin
        sample_col_next = col_inc[sbd_pkg::POS_W-1:0];
        if (({1'b0, sub_col} + sbd_pkg::SS_W'(1)) >= cfg.ss) begin
          sub_col_next   = '0;
          block_col_next = block_col + sbd_pkg::POS_W'(1);
        end else begin
          sub_col_next = sub_col + sbd_pkg::SUB_W'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_col <= '0;
      sample_row <= '0;
      sub_col    <= '0;
      sub_row    <= '0;
      block_col  <= '0;
      v1         <= 1'b0;
      fwd_v      <= 1'b0;
    end else begin
      sample_col <= sample_col_next;
      sample_row <= sample_row_next;
      sub_col    <= sub_col_next;
      sub_row    <= sub_row_next;
      block_col  <= block_col_next;
      v1         <= in_valid && in_block;
      if (v1) fwd_v <= 1'b1;
    end
  end

  // payload of the read-modify-write stage
  always_ff @(posedge clk) begin
    if (in_valid) begin
      emit1  <= last_blk;
      first1 <= first;
      fend1  <= fend;
      cov1   <= coverage;
      addr1  <= block_col;
    end
    if (v1) begin
      fwd_addr <= addr1;
      fwd_sum  <= sum;
    end
  end

  sbd_ram #(
    .WIDTH (sbd_pkg::SUM_W),
    .DEPTH (sbd_pkg::MAX_HI_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (v1),
    .waddr (addr1),
    .wdata (sum),
    .re    (in_valid),
    .raddr (block_col),
    .rdata (rdata)
  );

  // add the sample onto the column sum, or restart it on a block's first sample
  always_comb begin
    fwd_hit = fwd_v && (fwd_addr == addr1);
    base    = fwd_hit ? fwd_sum : rdata;
    sum     = first1 ? sbd_pkg::SUM_W'(cov1) : base + sbd_pkg::SUM_W'(cov1);
  end

  always_comb begin
    acc.valid     = v1 && emit1;
    acc.sum       = sum;
    acc.frame_end = fend1;
  end

  // back-to-back updates of one column must take the forwarded sum
  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    (v1 && $past(v1) && (addr1 == $past(addr1))) |-> fwd_hit)
    else $error("same-column update missed the forwarded sum");

endmodule

@@ design/sbd_alpha.sv @@
// sbd_alpha: divides block sums by ss*ss, saturates to a byte and queues
// the pixels for the output stream. Depends on sbd_pkg.
module sbd_alpha (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sbd_pkg::IDX_W-1:0]   ss_idx,
  input  sbd_pkg::sum_t               acc,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [sbd_pkg::ALPHA_W-1:0] alpha,
  output logic                        m_tlast,
  output logic [sbd_pkg::OCC_W-1:0]   occupancy
);

  localparam int PROD_W = sbd_pkg::SUM_W + sbd_pkg::SQ_MW;
  localparam int Q_W    = PROD_W - sbd_pkg::SQ_K;

  logic                        a_v;
  logic [sbd_pkg::SUM_W-1:0]   a_sum;
  logic                        a_fend;
  logic [PROD_W-1:0]           prod;
  logic                        b_v;
  logic [Q_W-1:0]              b_q;
  logic                        b_fend;
  logic [sbd_pkg::ALPHA_W-1:0] sat;

  logic [sbd_pkg::ALPHA_W:0]   fifo [sbd_pkg::FIFO_DEPTH];
  logic [sbd_pkg::FIFO_AW-1:0] wr_ptr;
  logic [sbd_pkg::FIFO_AW-1:0] rd_ptr;
  logic [sbd_pkg::CNT_W-1:0]   count;
  logic                        push;
  logic                        pop;

  // operand and product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= acc.valid;
      b_v <= a_v;
    end
  end

  assign prod = {{sbd_pkg::SQ_MW{1'b0}}, a_sum} *
                {{sbd_pkg::SUM_W{1'b0}}, sbd_pkg::SQ_RECIP[ss_idx]};

  always_ff @(posedge clk) begin
    a_sum  <= acc.sum;
    a_fend <= acc.frame_end;
    b_q    <= prod[PROD_W-1:sbd_pkg::SQ_K];
    b_fend <= a_fend;
  end

  // saturate to a byte
  assign sat = (b_q > Q_W'(255)) ? {sbd_pkg::ALPHA_W{1'b1}} : b_q[sbd_pkg::ALPHA_W-1:0];

  // pixel queue
  assign push = b_v;
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= {b_fend, sat};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + sbd_pkg::FIFO_AW'(1);
      if (pop) rd_ptr <= rd_ptr + sbd_pkg::FIFO_AW'(1);
      if (push && !pop) count <= count + sbd_pkg::CNT_W'(1);
      else if (pop && !push) count <= count - sbd_pkg::CNT_W'(1);
    end
  end

  assign m_tvalid = (count != '0);
  assign alpha    = fifo[rd_ptr][sbd_pkg::ALPHA_W-1:0];
  assign m_tlast  = fifo[rd_ptr][sbd_pkg::ALPHA_W];

  // every pixel in flight has a queue slot reserved
  assign occupancy = sbd_pkg::OCC_W'(count) + sbd_pkg::OCC_W'(a_v) +
                     sbd_pkg::OCC_W'(b_v) + sbd_pkg::OCC_W'(acc.valid);

  // the credit check at the input keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < sbd_pkg::CNT_W'(sbd_pkg::FIFO_DEPTH)))
    else $error("pixel queue overflow");

endmodule

@@ design/supersample_box_downsample_rgba.sv @@
// supersample_box_downsample_rgba: top level of the box downsampler.
// Depends on sbd_pkg, sbd_cfg, sbd_accum, sbd_alpha (and sbd_ram below it).
//
// Usage:
//   Coverage samples of a supersampled mask enter on the s_ stream in raster
//   order, one 8-bit sample per transfer. Each ss-by-ss block of samples is
//   summed in a 4096-entry column-sum RAM (read, add, write back, with the
//   last write forwarded to a racing read). The sample that completes a block
//   yields one pixel on the m_ stream: the fill color and alpha = sum/(ss*ss)
//   rounded down; m_tlast marks the last pixel of the frame. Samples right of
//   or below the last whole block give no pixel.
//   Throughput is one sample per cycle while s_tready is high, set by the
//   read-modify-write of the column-sum RAM. From the sample transfer to
//   m_tvalid a pixel passes the RAM read with the add, the reciprocal
//   multiply and the saturation into the queue.
//   Pixels wait in an 8-entry queue; s_tready stays high while the queue has
//   room for every pixel still in flight, so a stalled receiver throttles the
//   input only once that room is used up.
//   Reset clears the raster position and loads the register defaults. After
//   reset and after every register write s_tready is low while the
//   block-aligned limits are recomputed. The column-sum RAM is not cleared.
module supersample_box_downsample_rgba (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] coverage
  // pixel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic        m_tlast    // frame_end
);

  sbd_pkg::cfg_t                 cfg;
  sbd_pkg::sum_t                 acc;
  logic                          busy;
  logic                          in_valid;
  logic [sbd_pkg::ALPHA_W-1:0]   alpha;
  logic [sbd_pkg::OCC_W-1:0]     occupancy;

  assign pready = 1'b1;

  sbd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .busy    (busy)
  );

  // accept a sample only with a queue slot free for it and the limits settled
  assign s_tready = !busy && (occupancy < sbd_pkg::OCC_W'(sbd_pkg::FIFO_DEPTH));
  assign in_valid = s_tvalid && s_tready;

  sbd_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .coverage (s_tdata),
    .acc      (acc)
  );

  sbd_alpha u_alpha (
    .clk       (clk),
    .rst       (rst),
    .ss_idx    (cfg.ss_idx),
    .acc       (acc),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .alpha     (alpha),
    .m_tlast   (m_tlast),
    .occupancy (occupancy)
  );

  assign m_tdata = {alpha, cfg.blue, cfg.green, cfg.red};

  // limits are still settling right after reset
  a_reset_holdoff: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !s_tready)
    else $error("sample accepted before limits settled");

endmodule
